@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mpls_pkg.sv @@
// ----------------------------------------------------------------------------
// mpls_pkg
// Shared types and codes of the multi-press light sequencer.
// ----------------------------------------------------------------------------
package mpls_pkg;

    localparam int NOW_W      = 32;
    localparam int INTERVAL_W = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd50;

    // Light codes
    localparam logic [1:0] LIGHT_RED    = 2'd0;
    localparam logic [1:0] LIGHT_YELLOW = 2'd1;
    localparam logic [1:0] LIGHT_GREEN  = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_BACK    = 2'd2;

    // Press tally values
    localparam logic [1:0] TALLY_ZERO    = 2'd0;
    localparam logic [1:0] TALLY_ONE     = 2'd1;
    localparam logic [1:0] TALLY_ADVANCE = 2'd2;
    localparam logic [1:0] TALLY_MAX     = 2'd3;

    typedef struct packed {
        logic             button_level;
        logic [NOW_W-1:0] now_tick;
    } t_sample;

endpackage

@@ hw/rtl/mpls_ifs.sv @@
// ----------------------------------------------------------------------------
// mpls_ifs
// Valid/ready channel interfaces: button samples, results, register writes.
// ----------------------------------------------------------------------------
interface sample_if;
    logic        valid;
    logic        ready;
    logic        button_level;
    logic [31:0] now_tick;

    modport source (output valid, output button_level, output now_tick, input ready);
    modport sink   (input valid, input button_level, input now_tick, output ready);
endinterface

interface result_if;
    logic       valid;
    logic       ready;
    logic [1:0] light_state;
    logic       red_on;
    logic       yellow_on;
    logic       green_on;
    logic [1:0] action_taken;

    modport source (output valid, output light_state, output red_on, output yellow_on,
                    output green_on, output action_taken, input ready);
    modport sink   (input valid, input light_state, input red_on, input yellow_on,
                    input green_on, input action_taken, output ready);
endinterface

interface cfg_wr_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/mpls_in_stage.sv @@
// ----------------------------------------------------------------------------
// mpls_in_stage
// Input register: holds one button sample until the step stage takes it.
// ----------------------------------------------------------------------------
module mpls_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sample_if.sink             i_sample,
    input  logic               i_take,
    output logic               o_valid,
    output mpls_pkg::t_sample  o_sample
);

    logic              r_valid;
    mpls_pkg::t_sample r_sample;
    logic              load;

    assign i_sample.ready = !r_valid || i_take;
    assign load           = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sample.button_level <= i_sample.button_level;
            r_sample.now_tick     <= i_sample.now_tick;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

@@ hw/rtl/mpls_core.sv @@
// ----------------------------------------------------------------------------
// mpls_core
// Press grouping, idle timeout and light stepping; owns the result register.
// ----------------------------------------------------------------------------
module mpls_core #(
    parameter int TICK_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfg_wr_if.sink             i_cfg,
    input  logic               i_valid,
    input  mpls_pkg::t_sample  i_sample,
    output logic               o_take,
    result_if.source           o_result
);

    localparam int CW = (TICK_WIDTH > mpls_pkg::NOW_W) ? TICK_WIDTH : mpls_pkg::NOW_W;

    logic [mpls_pkg::INTERVAL_W-1:0] r_interval;
    logic [1:0]                      r_light, n_light;
    logic [1:0]                      r_tally, n_tally;
    logic [TICK_WIDTH-1:0]           r_last, n_last;
    logic                            r_prev;
    logic                            r_out_valid;
    logic [1:0]                      r_action, n_action;

    logic [CW-1:0]         now_w;
    logic [TICK_WIDTH-1:0] now_t;
    logic [TICK_WIDTH-1:0] since_press;
    logic [TICK_WIDTH-1:0] idle_ticks;
    logic [CW-1:0]         interval_w;
    logic                  press;
    logic                  grouped;
    logic [1:0]            tally_p;
    logic                  fire;

    assign i_cfg.ready = 1'b1;

    // Take the sample modulo 2^TICK_WIDTH
    assign now_w      = CW'(i_sample.now_tick);
    assign now_t      = now_w[TICK_WIDTH-1:0];
    assign interval_w = CW'(r_interval);

    assign press       = i_sample.button_level && !r_prev;
    assign since_press = now_t - r_last;
    assign grouped     = CW'(since_press) < interval_w;

    always_comb begin
        tally_p = r_tally;
        n_last  = r_last;
        if (press) begin
            n_last = now_t;
            if (!grouped) begin
                tally_p = mpls_pkg::TALLY_ONE;
            end else if (r_tally != mpls_pkg::TALLY_MAX) begin
                tally_p = r_tally + 2'd1;
            end
        end
    end

    assign idle_ticks = now_t - n_last;
    assign fire       = (CW'(idle_ticks) >= interval_w) && (tally_p != mpls_pkg::TALLY_ZERO);

    always_comb begin
        n_light  = r_light;
        n_action = mpls_pkg::ACT_NONE;
        n_tally  = tally_p;
        if (fire) begin
            n_tally = mpls_pkg::TALLY_ZERO;
            if (tally_p == mpls_pkg::TALLY_ADVANCE) begin
                n_action = mpls_pkg::ACT_ADVANCE;
                n_light  = (r_light >= mpls_pkg::LIGHT_GREEN) ? mpls_pkg::LIGHT_RED
                                                              : r_light + 2'd1;
            end else if (tally_p == mpls_pkg::TALLY_MAX) begin
                n_action = mpls_pkg::ACT_BACK;
                n_light  = (r_light == mpls_pkg::LIGHT_RED || r_light > mpls_pkg::LIGHT_GREEN)
                         ? mpls_pkg::LIGHT_GREEN : r_light - 2'd1;
            end
        end
    end

    assign o_take = i_valid && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= mpls_pkg::INTERVAL_RESET;
            r_light     <= mpls_pkg::LIGHT_RED;
            r_tally     <= mpls_pkg::TALLY_ZERO;
            r_last      <= '0;
            r_prev      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_interval <= i_cfg.data;
            end
            if (o_take) begin
                r_light     <= n_light;
                r_tally     <= n_tally;
                r_last      <= n_last;
                r_prev      <= i_sample.button_level;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_action <= n_action;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.light_state  = r_light;
    assign o_result.red_on       = (r_light == mpls_pkg::LIGHT_RED);
    assign o_result.yellow_on    = (r_light == mpls_pkg::LIGHT_YELLOW);
    assign o_result.green_on     = (r_light == mpls_pkg::LIGHT_GREEN);
    assign o_result.action_taken = r_action;

endmodule

@@ hw/rtl/multi_press_light_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_press_light_sequencer_unit
// Groups button presses in time and steps a red/yellow/green light.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample  - one item per button sample: level and tick count at the sample.
//   o_result  - one item per sample: light after the sample, lamp drives and
//               the action taken (none, advance, step back).
//   i_cfg     - write of the press interval in ticks; always ready. Write it
//               only while no sample is in flight.
// Path: an accepted sample waits in the input register, then one
//   combinational step writes its result into the result register.
//   Throughput: one item per cycle while o_result is not held, set by the step
//   that reads and updates the tally, last-press tick and light registers.
// Stall: while o_result is held the step stage stops; the input register
//   still takes one more sample, then i_sample.ready drops.
// Reset (i_rst_n low at a clock edge): light red, tally cleared, last press
//   tick zero, previous level low, interval 50 ticks, both stages empty.
// ----------------------------------------------------------------------------
module multi_press_light_sequencer_unit #(
    parameter int TICK_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sample_if.sink   i_sample,
    cfg_wr_if.sink   i_cfg,
    result_if.source o_result
);

    logic              stage_valid;
    logic              stage_take;
    mpls_pkg::t_sample stage_sample;

    // Hold the incoming sample until the step stage can use it
    mpls_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_take   (stage_take),
        .o_valid  (stage_valid),
        .o_sample (stage_sample)
    );

    // Update press tally and light; drive the result register
    mpls_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_valid  (stage_valid),
        .i_sample (stage_sample),
        .o_take   (stage_take),
        .o_result (o_result)
    );

endmodule

@@ hw/rtl/mpls_checker.sv @@
// ----------------------------------------------------------------------------
// mpls_checker
// Port-level checks of the light sequencer's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_light_state,
    input logic       i_red_on,
    input logic       i_yellow_on,
    input logic       i_green_on,
    input logic [1:0] i_action_taken
);

    logic stalled;
    logic lamps_ok;
    logic action_ok;

    assign stalled   = i_out_valid && !i_out_ready;
    assign lamps_ok  = $onehot({i_red_on, i_yellow_on, i_green_on})
                    && (i_red_on == (i_light_state == mpls_pkg::LIGHT_RED))
                    && (i_green_on == (i_light_state == mpls_pkg::LIGHT_GREEN));
    assign action_ok = (i_action_taken == mpls_pkg::ACT_NONE)
                    || (i_action_taken == mpls_pkg::ACT_ADVANCE)
                    || (i_action_taken == mpls_pkg::ACT_BACK);

    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, stalled, i_out_valid, "result dropped while stalled")

    `ASSERT_NEXT(a_light_stable, i_clk, i_rst_n, stalled,
                 $stable({i_light_state, i_action_taken}), "result changed while stalled")

    `ASSERT_IMPL(a_lamp_match, i_clk, i_rst_n, i_out_valid, lamps_ok, "lamps disagree with light")

    `ASSERT_IMPL(a_action_code, i_clk, i_rst_n, i_out_valid, action_ok, "bad action code")

endmodule

bind multi_press_light_sequencer_unit mpls_checker u_mpls_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_light_state  (o_result.light_state),
    .i_red_on       (o_result.red_on),
    .i_yellow_on    (o_result.yellow_on),
    .i_green_on     (o_result.green_on),
    .i_action_taken (o_result.action_taken)
);
